// ===== design/ftne_pkg.sv =====
// ----------------------------------------------------------------------------
// ftne_pkg
// Shared types and constants of the frame table evictor: table geometry,
// operation and status codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ftne_pkg;

	// table geometry
	localparam int NUM_FRAMES   = 64;
	localparam int FRAME_W      = $clog2(NUM_FRAMES);
	localparam int TAG_W        = 20;
	localparam int OWNER_W      = 8;
	localparam int MAP_W        = TAG_W + OWNER_W;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;

	// free frame search works on groups of eight in-use bits
	localparam int GROUP_LSB_W  = 3;
	localparam int GROUP_SIZE   = 1 << GROUP_LSB_W;
	localparam int NUM_GROUPS   = NUM_FRAMES / GROUP_SIZE;
	localparam int GROUP_IDX_W  = FRAME_W - GROUP_LSB_W;

	// victim search: two rounds of a clean pass and a dirty pass
	localparam int PASS_W       = 2;
	localparam logic [PASS_W-1:0] PASS_LAST = 2'd3;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_PIN    = 2'd2;
	localparam logic [OP_W-1:0] OP_ACCESS = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NOT_USED = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NO_FRAME = 2'd2;

	// per-frame marks kept in the flag memory (in-use bits live in flops)
	typedef struct packed {
		logic dirty;
		logic acc;
		logic pin;
	} ftne_flags_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_APPLY,
		S_FREE_SCAN,
		S_VICT_SCAN,
		S_ALLOC,
		S_FAIL
	} ftne_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic group_step;
		logic scan_run;
		logic commit_apply;
		logic commit_alloc;
		logic commit_fail;
	} ftne_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_alloc;
		logic free_hit;
		logic group_last;
		logic scan_hit;
		logic scan_miss;
		logic out_free;
	} ftne_sts_t;

endpackage

// ===== design/ftne_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftne_ctrl
// Controller of the frame table evictor. Sequences the free frame search,
// the victim scan and the single-frame operations, and issues commands to
// the datapath.
// ----------------------------------------------------------------------------
module ftne_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ftne_pkg::ftne_sts_t sts,
	output ftne_pkg::ftne_cmd_t cmd
);
	import ftne_pkg::*;

	ftne_state_t state_q;
	ftne_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = sts.req_alloc ? S_FREE_SCAN : S_RD;
				end
			end
			S_RD: begin
				state_nxt = S_APPLY;
			end
			S_APPLY: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_FREE_SCAN: begin
				if (sts.free_hit) begin
					state_nxt = S_ALLOC;
				end else if (sts.group_last) begin
					state_nxt = S_VICT_SCAN;
				end
			end
			S_VICT_SCAN: begin
				if (sts.scan_hit) begin
					state_nxt = S_ALLOC;
				end else if (sts.scan_miss) begin
					state_nxt = S_FAIL;
				end
			end
			S_ALLOC, S_FAIL: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			S_APPLY: begin
				cmd.commit_apply = sts.out_free;
			end
			S_FREE_SCAN: begin
				cmd.group_step = 1'b1;
			end
			S_VICT_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			S_ALLOC: begin
				cmd.commit_alloc = sts.out_free;
			end
			S_FAIL: begin
				cmd.commit_fail = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/ftne_dp.sv =====
// ----------------------------------------------------------------------------
// ftne_dp
// Datapath of the frame table evictor: in-use bits, flag and mapping
// memories, the grouped free frame search, the pipelined victim scan and
// the result word register.
// ----------------------------------------------------------------------------
module ftne_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ftne_pkg::ftne_cmd_t               cmd,
	output ftne_pkg::ftne_sts_t               sts,
	input  logic [ftne_pkg::OP_W-1:0]         opcode,
	input  logic [ftne_pkg::FRAME_W-1:0]      frame_index,
	input  logic [ftne_pkg::TAG_W-1:0]        page_tag,
	input  logic [ftne_pkg::OWNER_W-1:0]      owner_id,
	input  logic                              pin_value,
	input  logic                              is_write,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [ftne_pkg::STATUS_W-1:0]     status,
	output logic [ftne_pkg::FRAME_W-1:0]      frame_out,
	output logic                              evicted,
	output logic                              victim_dirty,
	output logic [ftne_pkg::TAG_W-1:0]        victim_tag,
	output logic [ftne_pkg::OWNER_W-1:0]      victim_owner
);
	import ftne_pkg::*;

	localparam logic [FRAME_W-1:0]     LAST_FRAME = FRAME_W'(NUM_FRAMES - 1);
	localparam logic [GROUP_IDX_W-1:0] LAST_GROUP = GROUP_IDX_W'(NUM_GROUPS - 1);

	// held word
	logic [OP_W-1:0]    op_q;
	logic [FRAME_W-1:0] idx_q;
	logic [TAG_W-1:0]   tag_q;
	logic [OWNER_W-1:0] owner_q;
	logic               pin_q;
	logic               wr_q;

	// table state
	logic [NUM_FRAMES-1:0] used_q;
	ftne_flags_t           fl_mem [NUM_FRAMES];
	logic [MAP_W-1:0]      map_mem [NUM_FRAMES];
	ftne_flags_t           fl_rd_q;
	logic [MAP_W-1:0]      map_rd_q;

	// search state
	logic [GROUP_IDX_W-1:0] group_q;
	logic [FRAME_W-1:0]     ptr_q;
	logic [PASS_W-1:0]      pass_q;
	logic                   valid_s1;
	logic [FRAME_W-1:0]     idx_s1;
	logic [PASS_W-1:0]      pass_s1;

	// chosen frame and victim details
	logic [FRAME_W-1:0] slot_q;
	logic               ev_q;
	logic               vdirty_q;
	logic [TAG_W-1:0]   vtag_q;
	logic [OWNER_W-1:0] vowner_q;

	// result word register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FRAME_W-1:0]  frame_out_q;
	logic                evicted_q;
	logic                victim_dirty_q;
	logic [TAG_W-1:0]    victim_tag_q;
	logic [OWNER_W-1:0]  victim_owner_q;

	logic [GROUP_SIZE-1:0]  grp_free;
	logic [GROUP_LSB_W-1:0] grp_enc;
	logic                   grp_hit;
	logic [FRAME_W-1:0]     rd_addr;
	logic                   elig;
	logic                   scan_hit;
	logic                   scan_clr;
	logic                   scan_miss;
	logic                   apply_used;
	logic                   out_free;
	logic                   fl_we;
	logic [FRAME_W-1:0]     fl_wa;
	ftne_flags_t            fl_wd;

	// lowest free frame within the current group of eight
	always_comb begin
		grp_free = ~used_q[{group_q, {GROUP_LSB_W{1'b0}}} +: GROUP_SIZE];
		grp_hit  = |grp_free;
		grp_enc  = '0;
		for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
			if (grp_free[i]) begin
				grp_enc = GROUP_LSB_W'(i);
			end
		end
	end

	// victim test on the frame read in the previous cycle
	always_comb begin
		elig      = valid_s1 & used_q[idx_s1] & ~fl_rd_q.pin;
		scan_hit  = elig & ~fl_rd_q.acc & (fl_rd_q.dirty == pass_s1[0]);
		scan_clr  = elig & pass_s1[0] & ~scan_hit;
		scan_miss = valid_s1 & ~scan_hit & (idx_s1 == LAST_FRAME) & (pass_s1 == PASS_LAST);
	end

	assign apply_used = used_q[idx_q];
	assign out_free   = ~rsp_valid_q | ~rsp_stall;
	assign rd_addr    = cmd.scan_run ? ptr_q : idx_q;

	// status towards the controller
	always_comb begin
		sts.req_alloc  = (opcode == OP_ALLOC);
		sts.free_hit   = grp_hit;
		sts.group_last = (group_q == LAST_GROUP);
		sts.scan_hit   = scan_hit;
		sts.scan_miss  = scan_miss;
		sts.out_free   = out_free;
	end

	// flag memory write selection
	always_comb begin
		fl_we = 1'b0;
		fl_wa = idx_q;
		fl_wd = fl_rd_q;
		if (cmd.scan_run && scan_clr) begin
			fl_we     = 1'b1;
			fl_wa     = idx_s1;
			fl_wd     = fl_rd_q;
			fl_wd.acc = 1'b0;
		end else if (cmd.commit_alloc) begin
			fl_we = 1'b1;
			fl_wa = slot_q;
			fl_wd = '0;
		end else if (cmd.commit_apply && apply_used) begin
			case (op_q)
				OP_PIN: begin
					fl_we     = 1'b1;
					fl_wd.pin = pin_q;
				end
				OP_ACCESS: begin
					fl_we       = 1'b1;
					fl_wd.acc   = 1'b1;
					fl_wd.dirty = fl_rd_q.dirty | wr_q;
				end
				default: begin
					fl_we = 1'b0;
				end
			endcase
		end
	end

	// flag and mapping memories, read data registered
	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_wa] <= fl_wd;
		end
		if (cmd.commit_alloc) begin
			map_mem[slot_q] <= {owner_q, tag_q};
		end
		fl_rd_q  <= fl_mem[rd_addr];
		map_rd_q <= map_mem[rd_addr];
	end

	// in-use bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.commit_alloc) begin
			used_q[slot_q] <= 1'b1;
		end else if (cmd.commit_apply && apply_used && op_q == OP_FREE) begin
			used_q[idx_q] <= 1'b0;
		end
	end

	// held word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			idx_q   <= frame_index;
			tag_q   <= page_tag;
			owner_q <= owner_id;
			pin_q   <= pin_value;
			wr_q    <= is_write;
		end
	end

	// search counters and scan stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q  <= '0;
			ptr_q    <= '0;
			pass_q   <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			pass_s1  <= '0;
		end else if (cmd.load) begin
			group_q  <= '0;
			ptr_q    <= '0;
			pass_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.group_step) begin
				group_q <= group_q + 1'b1;
			end
			if (cmd.scan_run) begin
				valid_s1 <= 1'b1;
				idx_s1   <= ptr_q;
				pass_s1  <= pass_q;
				if (ptr_q == LAST_FRAME) begin
					ptr_q  <= '0;
					pass_q <= pass_q + 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	// chosen frame and victim capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_q     <= 1'b0;
			vdirty_q <= 1'b0;
			vtag_q   <= '0;
			vowner_q <= '0;
		end else if (cmd.group_step && grp_hit) begin
			slot_q <= {group_q, grp_enc};
		end else if (cmd.scan_run && scan_hit) begin
			slot_q   <= idx_s1;
			ev_q     <= 1'b1;
			vdirty_q <= fl_rd_q.dirty;
			vtag_q   <= map_rd_q[TAG_W-1:0];
			vowner_q <= map_rd_q[TAG_W +: OWNER_W];
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit_apply || cmd.commit_alloc || cmd.commit_fail) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (cmd.commit_apply) begin
			status_q       <= apply_used ? STS_OK : STS_NOT_USED;
			frame_out_q    <= idx_q;
			evicted_q      <= 1'b0;
			victim_dirty_q <= 1'b0;
			victim_tag_q   <= '0;
			victim_owner_q <= '0;
		end else if (cmd.commit_alloc) begin
			status_q       <= STS_OK;
			frame_out_q    <= slot_q;
			evicted_q      <= ev_q;
			victim_dirty_q <= vdirty_q;
			victim_tag_q   <= vtag_q;
			victim_owner_q <= vowner_q;
		end else if (cmd.commit_fail) begin
			status_q       <= STS_NO_FRAME;
			frame_out_q    <= '0;
			evicted_q      <= 1'b0;
			victim_dirty_q <= 1'b0;
			victim_tag_q   <= '0;
			victim_owner_q <= '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign frame_out    = frame_out_q;
	assign evicted      = evicted_q;
	assign victim_dirty = victim_dirty_q;
	assign victim_tag   = victim_tag_q;
	assign victim_owner = victim_owner_q;

endmodule

// ===== design/frame_table_nru_evictor.sv =====
// ----------------------------------------------------------------------------
// frame_table_nru_evictor
// Physical frame table with a not-recently-used victim picker. Each request
// word carries one operation (allocate, free, set pin, record access) and
// gives exactly one response word.
//
// Request channel: req_valid / req_stall with the operation fields. Response
// channel: rsp_valid / rsp_stall with status, granted frame and victim data.
// A word moves on a rising edge with valid high and stall low.
//
// One request is worked on at a time; req_stall is high from acceptance
// until the response has been loaded into the response register.
// Free, set pin and record access: the response follows a flag memory read,
// then the update. Allocate with a free frame: the response follows the search
// over the in-use bits in groups of eight. Allocate that must evict or that
// finds every frame pinned: the response follows the victim scan, reading one
// frame per cycle over at most four passes of 64 frames.
// While the response register is held by rsp_stall the block waits before
// committing the next result; a new request is still taken in that time.
// After reset every frame is free and no response is pending.
// ----------------------------------------------------------------------------
module frame_table_nru_evictor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [ftne_pkg::OP_W-1:0]         opcode,
	input  logic [ftne_pkg::FRAME_W-1:0]      frame_index,
	input  logic [ftne_pkg::TAG_W-1:0]        page_tag,
	input  logic [ftne_pkg::OWNER_W-1:0]      owner_id,
	input  logic                              pin_value,
	input  logic                              is_write,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [ftne_pkg::STATUS_W-1:0]     status,
	output logic [ftne_pkg::FRAME_W-1:0]      frame_out,
	output logic                              evicted,
	output logic                              victim_dirty,
	output logic [ftne_pkg::TAG_W-1:0]        victim_tag,
	output logic [ftne_pkg::OWNER_W-1:0]      victim_owner
);
	import ftne_pkg::*;

	ftne_cmd_t cmd;
	ftne_sts_t sts;

	// sequencing
	ftne_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, search and response register
	ftne_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.frame_index  (frame_index),
		.page_tag     (page_tag),
		.owner_id     (owner_id),
		.pin_value    (pin_value),
		.is_write     (is_write),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.frame_out    (frame_out),
		.evicted      (evicted),
		.victim_dirty (victim_dirty),
		.victim_tag   (victim_tag),
		.victim_owner (victim_owner)
	);

endmodule
